// File: hw/rtl/wrp_pkg.sv
// Shared types and constants for the WAV header parser.
package wrp_pkg;

    localparam logic [31:0] SIG_RIFF      = 32'h4646_4952;
    localparam logic [31:0] SIG_WAVE      = 32'h4556_4157;
    localparam logic [31:0] SIG_FMT       = 32'h2074_6D66;
    localparam logic [31:0] SIG_DATA      = 32'h6174_6164;
    localparam logic [31:0] SIG_SMPL      = 32'h6C70_6D73;
    localparam logic [31:0] FMT_BASE_LEN  = 32'd16;
    localparam logic [31:0] SMPL_HEAD_LEN = 32'd28;
    localparam logic [31:0] LOOP_REC_LAST = 32'd23;

    localparam int OUT_DATA_W = 232;

    typedef enum logic [4:0] {
        PH_RIFF         = 5'd0,
        PH_RIFFSIZE     = 5'd1,
        PH_WAVE         = 5'd2,
        PH_FMTID        = 5'd3,
        PH_PREFMT_SIZE  = 5'd4,
        PH_SKIP_PREFMT  = 5'd5,
        PH_FMTSIZE      = 5'd6,
        PH_FMTFIELDS    = 5'd7,
        PH_FMTRES       = 5'd8,
        PH_DATAID       = 5'd9,
        PH_PREDATA_SIZE = 5'd10,
        PH_SKIP_PREDATA = 5'd11,
        PH_DATASIZE     = 5'd12,
        PH_PAYLOAD      = 5'd13,
        PH_CHUNKID      = 5'd14,
        PH_CHUNKSIZE    = 5'd15,
        PH_SKIP_CHUNK   = 5'd16,
        PH_SMPL_HDR     = 5'd17,
        PH_NLOOPS       = 5'd18,
        PH_EXTRA        = 5'd19,
        PH_LOOP         = 5'd20,
        PH_SMPL_DATA    = 5'd21,
        PH_STOPPED      = 5'd22
    } phase_t;

    typedef enum logic [2:0] {
        EV_FORMAT  = 3'd0,
        EV_AUDIO   = 3'd1,
        EV_LOOP    = 3'd2,
        EV_NOTWAVE = 3'd3,
        EV_TRUNC   = 3'd4,
        EV_DONE    = 3'd5
    } ev_kind_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_marker;
    } item_t;

    typedef struct packed {
        logic       valid;
        ev_kind_t   kind;
        logic [7:0] audio;
    } event_t;

    typedef struct packed {
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [30:0] payload_length;
        logic [31:0] loop_start;
        logic [31:0] loop_end;
    } info_t;

endpackage

// File: hw/rtl/wrp_ingress.sv
// Input word register with pass-through ready.
module wrp_ingress
    import wrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [0:0] s_tuser,
    input  logic       take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.stream_byte <= s_tdata;
            item_reg.end_marker  <= s_tuser[0];
        end
    end

endmodule

// File: hw/rtl/wrp_parser.sv
// Header walk state machine and held format, data and loop fields.
module wrp_parser
    import wrp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   step,
    input  item_t  item,
    output event_t ev,
    output info_t  info
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  fib_reg, fib_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] fmt_len_reg, fmt_len_next;
    logic [30:0] pay_rem_reg, pay_rem_next;
    logic [31:0] loops_reg, loops_next;
    logic        slot_reg, slot_next;
    logic [31:0] extra_reg, extra_next;
    logic        is_smpl_reg, is_smpl_next;
    info_t       info_reg, info_next;

    logic [31:0] ws;
    logic [31:0] skip_dec;
    logic [31:0] skip_inc;
    logic [31:0] loops_dec;
    logic [30:0] pay_dec;

    assign info = info_reg;

    always_comb begin
        phase_next   = phase_reg;
        fib_next     = fib_reg;
        word_next    = word_reg;
        skip_next    = skip_reg;
        fmt_len_next = fmt_len_reg;
        pay_rem_next = pay_rem_reg;
        loops_next   = loops_reg;
        slot_next    = slot_reg;
        extra_next   = extra_reg;
        is_smpl_next = is_smpl_reg;
        info_next    = info_reg;
        ev.valid     = 1'b0;
        ev.kind      = EV_FORMAT;
        ev.audio     = 8'd0;

        ws        = {item.stream_byte, word_reg[31:8]};
        skip_dec  = skip_reg - 32'd1;
        skip_inc  = skip_reg + 32'd1;
        loops_dec = loops_reg - 32'd1;
        pay_dec   = pay_rem_reg - 31'd1;

        if (step && phase_reg != PH_STOPPED) begin
            if (item.end_marker) begin
                phase_next = PH_STOPPED;
                fib_next   = 2'd0;
                skip_next  = 32'd0;
                ev.valid   = 1'b1;
                ev.kind    = (phase_reg >= PH_CHUNKID) ? EV_DONE : EV_TRUNC;
            end else begin
                word_next = ws;
                case (phase_reg)
                    PH_SKIP_PREFMT, PH_FMTRES, PH_SKIP_PREDATA,
                    PH_SKIP_CHUNK, PH_SMPL_HDR, PH_SMPL_DATA: begin
                        skip_next = skip_dec;
                        if (skip_dec == 32'd0) begin
                            fib_next = 2'd0;
                            case (phase_reg)
                                PH_SKIP_PREFMT:             phase_next = PH_FMTID;
                                PH_FMTRES, PH_SKIP_PREDATA: phase_next = PH_DATAID;
                                PH_SMPL_HDR:                phase_next = PH_NLOOPS;
                                default:                    phase_next = PH_CHUNKID;
                            endcase
                        end
                    end
                    PH_PAYLOAD: begin
                        pay_rem_next = pay_dec;
                        if (pay_dec == 31'd0) begin
                            phase_next = PH_CHUNKID;
                            fib_next   = 2'd0;
                            skip_next  = 32'd0;
                        end
                        ev.valid = 1'b1;
                        ev.kind  = EV_AUDIO;
                        ev.audio = item.stream_byte;
                    end
                    PH_FMTFIELDS: begin
                        skip_next = skip_inc;
                        if (skip_reg == 32'd1) begin
                            info_next.format_tag = ws[31:16];
                        end else if (skip_reg == 32'd3) begin
                            info_next.channel_count = ws[31:16];
                        end else if (skip_reg == 32'd7) begin
                            info_next.sample_rate = ws;
                        end else if (skip_reg == 32'd11) begin
                            info_next.byte_rate = ws;
                        end else if (skip_reg == 32'd13) begin
                            info_next.block_align = ws[31:16];
                        end else if (skip_reg >= 32'd15) begin
                            info_next.sample_bits = ws[31:16];
                            fib_next = 2'd0;
                            if (!fmt_len_reg[31] && fmt_len_reg > FMT_BASE_LEN) begin
                                phase_next = PH_FMTRES;
                                skip_next  = fmt_len_reg - FMT_BASE_LEN;
                            end else begin
                                phase_next = PH_DATAID;
                                skip_next  = 32'd0;
                            end
                            ev.valid = 1'b1;
                            ev.kind  = EV_FORMAT;
                        end
                    end
                    PH_LOOP: begin
                        skip_next = skip_inc;
                        if (skip_reg == 32'd11 && !slot_reg) begin
                            info_next.loop_start = ws;
                        end else if (skip_reg == 32'd15 && !slot_reg) begin
                            info_next.loop_end = ws;
                            slot_next = 1'b1;
                            ev.valid  = 1'b1;
                            ev.kind   = EV_LOOP;
                        end else if (skip_reg >= LOOP_REC_LAST) begin
                            skip_next  = 32'd0;
                            loops_next = loops_dec;
                            if (loops_dec == 32'd0) begin
                                fib_next = 2'd0;
                                if (extra_reg == 32'd0) begin
                                    phase_next = PH_CHUNKID;
                                end else begin
                                    phase_next = PH_SMPL_DATA;
                                    skip_next  = extra_reg;
                                end
                            end
                        end
                    end
                    default: begin
                        if (fib_reg != 2'd3) begin
                            fib_next = fib_reg + 2'd1;
                        end else begin
                            fib_next  = 2'd0;
                            skip_next = 32'd0;
                            case (phase_reg)
                                PH_RIFF: begin
                                    if (ws != SIG_RIFF) begin
                                        phase_next = PH_STOPPED;
                                        ev.valid   = 1'b1;
                                        ev.kind    = EV_NOTWAVE;
                                    end else begin
                                        phase_next = PH_RIFFSIZE;
                                    end
                                end
                                PH_RIFFSIZE: phase_next = PH_WAVE;
                                PH_WAVE: begin
                                    if (ws != SIG_WAVE) begin
                                        phase_next = PH_STOPPED;
                                        ev.valid   = 1'b1;
                                        ev.kind    = EV_NOTWAVE;
                                    end else begin
                                        phase_next = PH_FMTID;
                                    end
                                end
                                PH_FMTID: begin
                                    phase_next = (ws == SIG_FMT) ? PH_FMTSIZE : PH_PREFMT_SIZE;
                                end
                                PH_PREFMT_SIZE: begin
                                    if (ws[31] || ws == 32'd0) begin
                                        phase_next = PH_FMTID;
                                    end else begin
                                        phase_next = PH_SKIP_PREFMT;
                                        skip_next  = ws;
                                    end
                                end
                                PH_FMTSIZE: begin
                                    fmt_len_next = ws;
                                    phase_next   = PH_FMTFIELDS;
                                end
                                PH_DATAID: begin
                                    phase_next = (ws == SIG_DATA) ? PH_DATASIZE
                                                                  : PH_PREDATA_SIZE;
                                end
                                PH_PREDATA_SIZE: begin
                                    if (ws[31] || ws == 32'd0) begin
                                        phase_next = PH_DATAID;
                                    end else begin
                                        phase_next = PH_SKIP_PREDATA;
                                        skip_next  = ws;
                                    end
                                end
                                PH_DATASIZE: begin
                                    if (ws[31] || ws[30:0] == 31'd0) begin
                                        info_next.payload_length = 31'd0;
                                        pay_rem_next             = 31'd0;
                                        phase_next               = PH_CHUNKID;
                                    end else begin
                                        info_next.payload_length = ws[30:0];
                                        pay_rem_next             = ws[30:0];
                                        phase_next               = PH_PAYLOAD;
                                    end
                                end
                                PH_CHUNKID: begin
                                    is_smpl_next = (ws == SIG_SMPL);
                                    phase_next   = PH_CHUNKSIZE;
                                end
                                PH_CHUNKSIZE: begin
                                    if (is_smpl_reg) begin
                                        slot_next  = 1'b0;
                                        phase_next = PH_SMPL_HDR;
                                        skip_next  = SMPL_HEAD_LEN;
                                    end else if (ws[31] || ws == 32'd0) begin
                                        phase_next = PH_CHUNKID;
                                    end else begin
                                        phase_next = PH_SKIP_CHUNK;
                                        skip_next  = ws;
                                    end
                                end
                                PH_NLOOPS: begin
                                    loops_next = ws;
                                    phase_next = PH_EXTRA;
                                end
                                PH_EXTRA: begin
                                    extra_next = ws[31] ? 32'd0 : ws;
                                    if (loops_reg != 32'd0) begin
                                        phase_next = PH_LOOP;
                                    end else if (ws[31] || ws == 32'd0) begin
                                        phase_next = PH_CHUNKID;
                                    end else begin
                                        phase_next = PH_SMPL_DATA;
                                        skip_next  = ws;
                                    end
                                end
                                default: phase_next = PH_STOPPED;
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_RIFF;
            fib_reg     <= 2'd0;
            word_reg    <= 32'd0;
            skip_reg    <= 32'd0;
            fmt_len_reg <= 32'd0;
            pay_rem_reg <= 31'd0;
            loops_reg   <= 32'd0;
            slot_reg    <= 1'b0;
            extra_reg   <= 32'd0;
            is_smpl_reg <= 1'b0;
            info_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            fib_reg     <= fib_next;
            word_reg    <= word_next;
            skip_reg    <= skip_next;
            fmt_len_reg <= fmt_len_next;
            pay_rem_reg <= pay_rem_next;
            loops_reg   <= loops_next;
            slot_reg    <= slot_next;
            extra_reg   <= extra_next;
            is_smpl_reg <= is_smpl_next;
            info_reg    <= info_next;
        end
    end

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_STOPPED |=> phase_reg == PH_STOPPED)
        else $error("left stopped phase");

    a_audio_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev.valid && ev.kind == EV_AUDIO) |-> phase_reg == PH_PAYLOAD)
        else $error("audio word outside payload");

    a_loop_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev.valid && ev.kind == EV_LOOP) |=> slot_reg)
        else $error("loop slot not closed after loop event");

    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> pay_rem_reg != 31'd0)
        else $error("payload phase with zero remaining");

endmodule

// File: hw/rtl/wrp_egress.sv
// Result word register: event kind and audio byte.
module wrp_egress
    import wrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  event_t     ev,
    input  logic       m_tready,
    output logic       m_tvalid,
    output logic       free,
    output ev_kind_t   kind,
    output logic [7:0] audio
);

    logic       valid_reg, valid_next;
    ev_kind_t   kind_reg;
    logic [7:0] audio_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign kind     = kind_reg;
    assign audio    = audio_reg;

    always_comb begin
        valid_next = valid_reg;
        if (step) begin
            valid_next = ev.valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && ev.valid) begin
            kind_reg  <= ev.kind;
            audio_reg <= ev.audio;
        end
    end

endmodule

// File: hw/rtl/wave_riff_header_parser_core.sv
// Top level of the WAV header parser: input register, parser, result register.
//  channel | dir | tdata                 | tuser
//  s_      | in  | stream_byte           | end_marker
//  m_      | out | format and loop info  | event_kind
// One word is taken per cycle unless m_ stalls.
// Each word is handled by the combinational phase update between the two registers.
// Reset (aresetn low, synchronous) empties both registers and restarts at RIFF.
// A stalled m_ side holds the parser; s_ still fills the empty input register.
module wave_riff_header_parser_core
    import wrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // stream_byte
    input  logic [0:0]            s_tuser,  // end_marker
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // format_tag, channel_count, sample_rate, byte_rate, block_align,
    // sample_bits, payload_length, audio_byte, loop_start, loop_end, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]            m_tuser   // event_kind
);

    logic       item_valid;
    item_t      item;
    logic       free;
    logic       step;
    event_t     ev;
    info_t      info;
    ev_kind_t   kind;
    logic [7:0] audio;

    assign step = item_valid && free;

    wrp_ingress u_ingress (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    wrp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .ev      (ev),
        .info    (info)
    );

    wrp_egress u_egress (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .ev       (ev),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .free     (free),
        .kind     (kind),
        .audio    (audio)
    );

    assign m_tuser = kind;
    assign m_tdata = {1'b0, info.loop_end, info.loop_start, audio, info.payload_length,
                      info.sample_bits, info.block_align, info.byte_rate,
                      info.sample_rate, info.channel_count, info.format_tag};

endmodule

// File: test/wav_parse_checker.sv
// Checker for the WAV header parser: watches both channels, predicts every result and compares.
module wav_parse_checker
    import wrp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,  // stream_byte
    input  logic [0:0]            s_tuser,  // end_marker
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // format_tag, channel_count, sample_rate, byte_rate, block_align,
    // sample_bits, payload_length, audio_byte, loop_start, loop_end, zero pad
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [2:0]            m_tuser,  // event_kind
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        ev_kind_t   kind;
        info_t      info;
        logic [7:0] audio;
    } parse_event_t;

    parse_event_t expected_events[$];

    phase_t      phase;
    logic [2:0]  byte_pos;
    logic [31:0] shifter;
    logic [31:0] count;
    logic [31:0] fmt_len;
    info_t       held;
    logic [30:0] payload_left;
    logic [31:0] loops_left;
    logic        loop_taken;
    logic [31:0] smpl_extra;
    logic        in_smpl;

    function automatic void enter_phase(input phase_t p);
        phase    = p;
        byte_pos = '0;
        count    = '0;
    endfunction

    function automatic void enter_skip(input logic [31:0] n, input phase_t skip_p,
                                       input phase_t next_p);
        if (n == 0) begin
            enter_phase(next_p);
        end else begin
            enter_phase(skip_p);
            count = n;
        end
    endfunction

    function automatic logic [31:0] non_negative(input logic [31:0] v);
        return v[31] ? 32'd0 : v;
    endfunction

    function automatic void push_event(input ev_kind_t kind, input logic [7:0] audio);
        parse_event_t ev;
        ev.kind  = kind;
        ev.info  = held;
        ev.audio = audio;
        expected_events.push_back(ev);
    endfunction

    function automatic void reset_model();
        phase        = PH_RIFF;
        byte_pos     = '0;
        shifter      = '0;
        count        = '0;
        fmt_len      = '0;
        held         = '0;
        payload_left = '0;
        loops_left   = '0;
        loop_taken   = 1'b0;
        smpl_extra   = '0;
        in_smpl      = 1'b0;
        expected_events.delete();
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic em);
        phase_t      cur;
        logic [31:0] off;
        cur = phase;
        if (cur == PH_STOPPED)
            return;
        if (em) begin
            enter_phase(PH_STOPPED);
            push_event((cur >= PH_CHUNKID) ? EV_DONE : EV_TRUNC, 8'h00);
            return;
        end
        shifter = {b, shifter[31:8]};

        case (cur)
            PH_SKIP_PREFMT, PH_FMTRES, PH_SKIP_PREDATA,
            PH_SKIP_CHUNK, PH_SMPL_HDR, PH_SMPL_DATA: begin
                count = count - 1;
                if (count == 0) begin
                    case (cur)
                        PH_SKIP_PREFMT:            enter_phase(PH_FMTID);
                        PH_FMTRES, PH_SKIP_PREDATA: enter_phase(PH_DATAID);
                        PH_SMPL_HDR:               enter_phase(PH_NLOOPS);
                        default:                   enter_phase(PH_CHUNKID);
                    endcase
                end
                return;
            end
            PH_PAYLOAD: begin
                payload_left = payload_left - 31'd1;
                if (payload_left == 0)
                    enter_phase(PH_CHUNKID);
                push_event(EV_AUDIO, b);
                return;
            end
            PH_FMTFIELDS: begin
                off   = count;
                count = count + 1;
                if (off == 1) begin
                    held.format_tag = shifter[31:16];
                end else if (off == 3) begin
                    held.channel_count = shifter[31:16];
                end else if (off == 7) begin
                    held.sample_rate = shifter;
                end else if (off == 11) begin
                    held.byte_rate = shifter;
                end else if (off == 13) begin
                    held.block_align = shifter[31:16];
                end else if (off >= 15) begin
                    held.sample_bits = shifter[31:16];
                    if (!fmt_len[31] && fmt_len > FMT_BASE_LEN)
                        enter_skip(fmt_len - FMT_BASE_LEN, PH_FMTRES, PH_DATAID);
                    else
                        enter_phase(PH_DATAID);
                    push_event(EV_FORMAT, 8'h00);
                end
                return;
            end
            PH_LOOP: begin
                off   = count;
                count = count + 1;
                if (off == 11 && !loop_taken) begin
                    held.loop_start = shifter;
                end else if (off == 15 && !loop_taken) begin
                    held.loop_end = shifter;
                    loop_taken    = 1'b1;
                    push_event(EV_LOOP, 8'h00);
                end else if (off >= LOOP_REC_LAST) begin
                    count      = '0;
                    loops_left = loops_left - 1;
                    if (loops_left == 0)
                        enter_skip(smpl_extra, PH_SMPL_DATA, PH_CHUNKID);
                end
                return;
            end
            default: ;
        endcase

        // word-sized fields: act on the fourth byte
        if (byte_pos < 3) begin
            byte_pos = byte_pos + 3'd1;
            return;
        end
        byte_pos = '0;

        case (cur)
            PH_RIFF: begin
                if (shifter != SIG_RIFF) begin
                    enter_phase(PH_STOPPED);
                    push_event(EV_NOTWAVE, 8'h00);
                end else begin
                    enter_phase(PH_RIFFSIZE);
                end
            end
            PH_RIFFSIZE: enter_phase(PH_WAVE);
            PH_WAVE: begin
                if (shifter != SIG_WAVE) begin
                    enter_phase(PH_STOPPED);
                    push_event(EV_NOTWAVE, 8'h00);
                end else begin
                    enter_phase(PH_FMTID);
                end
            end
            PH_FMTID: enter_phase((shifter == SIG_FMT) ? PH_FMTSIZE : PH_PREFMT_SIZE);
            PH_PREFMT_SIZE: enter_skip(non_negative(shifter), PH_SKIP_PREFMT, PH_FMTID);
            PH_FMTSIZE: begin
                fmt_len = shifter;
                enter_phase(PH_FMTFIELDS);
            end
            PH_DATAID: enter_phase((shifter == SIG_DATA) ? PH_DATASIZE : PH_PREDATA_SIZE);
            PH_PREDATA_SIZE: enter_skip(non_negative(shifter), PH_SKIP_PREDATA, PH_DATAID);
            PH_DATASIZE: begin
                held.payload_length = shifter[31] ? 31'd0 : shifter[30:0];
                payload_left        = held.payload_length;
                enter_phase((payload_left == 0) ? PH_CHUNKID : PH_PAYLOAD);
            end
            PH_CHUNKID: begin
                in_smpl = (shifter == SIG_SMPL);
                enter_phase(PH_CHUNKSIZE);
            end
            PH_CHUNKSIZE: begin
                if (in_smpl) begin
                    loop_taken = 1'b0;
                    enter_skip(SMPL_HEAD_LEN, PH_SMPL_HDR, PH_NLOOPS);
                end else begin
                    enter_skip(non_negative(shifter), PH_SKIP_CHUNK, PH_CHUNKID);
                end
            end
            PH_NLOOPS: begin
                loops_left = shifter;
                enter_phase(PH_EXTRA);
            end
            PH_EXTRA: begin
                smpl_extra = non_negative(shifter);
                if (loops_left != 0)
                    enter_phase(PH_LOOP);
                else
                    enter_skip(smpl_extra, PH_SMPL_DATA, PH_CHUNKID);
            end
            default: enter_phase(PH_STOPPED);
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches = mismatches + 1;
        end
    endfunction

    always @(posedge aclk) begin
        parse_event_t ev;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $error("event_kind: expected no word, got %0d", m_tuser);
                    mismatches = mismatches + 1;
                end else begin
                    ev = expected_events.pop_front();
                    compare_field("event_kind", 32'(ev.kind), 32'(m_tuser));
                    compare_field("format_tag", 32'(ev.info.format_tag),
                                  32'(m_tdata[15:0]));
                    compare_field("channel_count", 32'(ev.info.channel_count),
                                  32'(m_tdata[31:16]));
                    compare_field("sample_rate", ev.info.sample_rate, m_tdata[63:32]);
                    compare_field("byte_rate", ev.info.byte_rate, m_tdata[95:64]);
                    compare_field("block_align", 32'(ev.info.block_align),
                                  32'(m_tdata[111:96]));
                    compare_field("sample_bits", 32'(ev.info.sample_bits),
                                  32'(m_tdata[127:112]));
                    compare_field("payload_length", 32'(ev.info.payload_length),
                                  32'(m_tdata[158:128]));
                    compare_field("audio_byte", 32'(ev.audio), 32'(m_tdata[166:159]));
                    compare_field("loop_start", ev.info.loop_start, m_tdata[198:167]);
                    compare_field("loop_end", ev.info.loop_end, m_tdata[230:199]);
                end
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tuser[0]);
        end
        outstanding <= expected_events.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the WAV header parser: clock, reset, file-byte stimulus and verdict.
module tb_top;
    import wrp_pkg::*;

    localparam int ITEM_TARGET = 1200;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;

    int mismatches;
    int outstanding;
    int sent     = 0;
    int src_idle = 0;
    int dst_idle = 0;

    wave_riff_header_parser_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    wav_parse_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_idle);
    end

    task automatic push_word(input logic [7:0] b, input logic em);
        if (sent < 400) begin
            src_idle = 31;
            dst_idle = 65;
        end else if (sent < 800) begin
            src_idle = 65;
            dst_idle = 31;
        end else begin
            src_idle = 0;
            dst_idle = 0;
        end
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= em;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic put_u32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            push_word(v[8*i +: 8], 1'b0);
    endtask

    task automatic put_noise(input int n);
        repeat (n) push_word(8'($urandom_range(255)), 1'b0);
    endtask

    function automatic logic [31:0] chunk_id(input logic [31:0] avoid);
        logic [31:0] id;
        case ($urandom_range(4))
            0:       id = SIG_FMT;
            1:       id = SIG_DATA;
            2:       id = SIG_SMPL;
            3:       id = SIG_RIFF;
            default: id = $urandom;
        endcase
        while (id == avoid)
            id = $urandom;
        return id;
    endfunction

    function automatic logic [31:0] chunk_size();
        if ($urandom_range(4) == 0)
            return $urandom | 32'h8000_0000;
        return $urandom_range(16);
    endfunction

    task automatic put_plain_chunk(input logic [31:0] avoid);
        logic [31:0] sz;
        sz = chunk_size();
        put_u32(chunk_id(avoid));
        put_u32(sz);
        if (!sz[31])
            put_noise(sz);
    endtask

    task automatic put_sampler(input int n_loops, input logic [31:0] first_start,
                               input logic [31:0] first_end);
        logic [31:0] extra;
        extra = ($urandom_range(3) == 0) ? ($urandom | 32'h8000_0000) : $urandom_range(12);
        put_u32(SIG_SMPL);
        put_u32($urandom);
        put_noise(SMPL_HEAD_LEN);
        put_u32(n_loops);
        put_u32(extra);
        for (int i = 0; i < n_loops; i++) begin
            put_noise(8);
            put_u32((i == 0) ? first_start : $urandom);
            put_u32((i == 0) ? first_end : $urandom);
            put_noise(8);
        end
        if (!extra[31])
            put_noise(extra);
    endtask

    initial begin : stimulus
        logic [31:0] fmt_size;
        logic [31:0] data_size;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        put_u32(SIG_RIFF);
        put_u32($urandom);
        put_u32(SIG_WAVE);

        // negative size before fmt skips nothing
        put_u32(32'h5453_494C);
        put_u32(32'hFFFF_FFFF);
        repeat ($urandom_range(2)) put_plain_chunk(SIG_FMT);

        case ($urandom_range(3))
            0:       fmt_size = FMT_BASE_LEN;
            1:       fmt_size = FMT_BASE_LEN + $urandom_range(1, 8);
            2:       fmt_size = $urandom_range(15);
            default: fmt_size = $urandom | 32'h8000_0000;
        endcase
        put_u32(SIG_FMT);
        put_u32(fmt_size);
        put_noise(FMT_BASE_LEN);
        if (!fmt_size[31] && fmt_size > FMT_BASE_LEN)
            put_noise(fmt_size - FMT_BASE_LEN);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);

        repeat ($urandom_range(2)) put_plain_chunk(SIG_DATA);

        if ($urandom_range(5) == 0)
            data_size = $urandom | 32'h8000_0000;
        else
            data_size = $urandom_range(200, 400);
        put_u32(SIG_DATA);
        put_u32(data_size);
        if (!data_size[31]) begin
            push_word(8'h00, 1'b0);
            push_word(8'hFF, 1'b0);
            put_noise(data_size - 2);
        end

        put_sampler(1, 32'h8000_0000, 32'h7FFF_FFFF);
        put_sampler(2, $urandom, $urandom);
        put_sampler(0, 32'h0, 32'h0);

        while (sent < ITEM_TARGET) begin
            if ($urandom_range(1) == 0)
                put_sampler($urandom_range(3), $urandom, $urandom);
            else
                put_plain_chunk(SIG_SMPL);
        end

        push_word(8'($urandom_range(255)), 1'b1);
        // the parser is stopped now; these must be dropped
        repeat (4) push_word(8'($urandom_range(255)), 1'($urandom_range(1)));

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            if (outstanding != 0)
                $error("%0d expected words never arrived", outstanding);
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/wrp_pkg.sv
hw/rtl/wrp_ingress.sv
hw/rtl/wrp_parser.sv
hw/rtl/wrp_egress.sv
hw/rtl/wave_riff_header_parser_core.sv
test/wav_parse_checker.sv
test/tb_top.sv
